/* sv/acsp_pkg.sv */
package acsp_pkg;

   // Default sizes handed to the top level.
   localparam int DEF_BUFFER_DEPTH = 16;
   localparam int DEF_MAX_ARGS     = 10;

   // Field widths fixed by the stream format.
   localparam int BYTE_W    = 8;
   localparam int CMD_W     = 4;
   localparam int ARG_SEL_W = 4;
   localparam int ARG_VAL_W = 16;
   localparam int DIGIT_W   = 4;

   // Characters of interest.
   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;

   // Result kinds.
   localparam logic KIND_RAW = 1'b0;
   localparam logic KIND_ARG = 1'b1;

   // Command codes; all but CUP follow the order of their final characters.
   localparam logic [CMD_W-1:0] CMD_INSERT = 4'd0;
   localparam logic [CMD_W-1:0] CMD_UP     = 4'd1;
   localparam logic [CMD_W-1:0] CMD_DOWN   = 4'd2;
   localparam logic [CMD_W-1:0] CMD_FWD    = 4'd3;
   localparam logic [CMD_W-1:0] CMD_BACK   = 4'd4;
   localparam logic [CMD_W-1:0] CMD_ED     = 4'd5;
   localparam logic [CMD_W-1:0] CMD_EL     = 4'd6;
   localparam logic [CMD_W-1:0] CMD_DCH    = 4'd7;
   localparam logic [CMD_W-1:0] CMD_CUP    = 4'd8;
   localparam logic [CMD_W-1:0] CMD_SGR    = 4'd9;

   // Operations of the argument accumulator.
   typedef enum logic [1:0] {
      ARG_NOP,
      ARG_CLEAR,
      ARG_DIGIT,
      ARG_COMMIT
   } arg_op_type;

   typedef struct packed {
      arg_op_type           op;
      logic [ARG_SEL_W-1:0] wr_idx;
      logic [DIGIT_W-1:0]   digit;
   } arg_ctl_type;

   // A final character closes any escape sequence.
   function automatic logic is_final(input logic [7:0] b);
      return b inside {[8'h40:8'h5A], [8'h61:8'h7A]};
   endfunction

   // Maps a final character to {known, command code}.
   function automatic logic [CMD_W:0] final_lookup(input logic [7:0] b);
      logic [CMD_W:0] r;
      case (b)
         8'h40:   r = {1'b1, CMD_INSERT};
         8'h41:   r = {1'b1, CMD_UP};
         8'h42:   r = {1'b1, CMD_DOWN};
         8'h43:   r = {1'b1, CMD_FWD};
         8'h44:   r = {1'b1, CMD_BACK};
         8'h4A:   r = {1'b1, CMD_ED};
         8'h4B:   r = {1'b1, CMD_EL};
         8'h50:   r = {1'b1, CMD_DCH};
         8'h48:   r = {1'b1, CMD_CUP};
         8'h6D:   r = {1'b1, CMD_SGR};
         default: r = {1'b0, CMD_INSERT};
      endcase
      return r;
   endfunction

endpackage

/* sv/ansi_csi_sequence_parser.sv */
// Channel  Direction  tdata                          tuser  tlast
// req      in         byte_in[7:0]                   -      -
// rsp      out        raw_byte, command, arg_total,  kind   last
//                     arg_index, arg_value
// csr      in         ansi_enable (csr_wr_data)      -      -
//
// A byte that is printed, buffered or passed through is taken only in IDLE; a raw
// result waits until the output register is free.
// A decode scans each byte of the argument area in PARSE_RD and PARSE_EX (one buffer
// read port), ends the scan, stores the last argument in COMMIT, then emits each argument.
// A replay reads each buffered byte through REP_RD and REP_OUT, paced by the buffer read port.
// reset is synchronous: no sequence open, ANSI processing on, no result held.
// A stall on rsp holds the sequencer in place; req is not ready while busy.
module ansi_csi_sequence_parser #(
   parameter int BUFFER_DEPTH = acsp_pkg::DEF_BUFFER_DEPTH,
   parameter int MAX_ARGS     = acsp_pkg::DEF_MAX_ARGS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] raw_byte, [11:8] command, [15:12] arg_total,
                                    // [19:16] arg_index, [35:20] arg_value, [39:36] zero
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast,   // last
   input  logic        csr_wr_en,
   input  logic        csr_wr_data  // ansi_enable
);
   import acsp_pkg::*;

   localparam int BIW   = $clog2(BUFFER_DEPTH);
   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
   localparam int AIW   = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;

   typedef enum logic [2:0] {
      IDLE,
      PARSE_RD,
      PARSE_EX,
      COMMIT,
      EMIT_RD,
      EMIT_OUT,
      REP_RD,
      REP_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic                 ansi_enable_ff, ansi_enable_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     ptr_ff, ptr_in;
   logic                 bracket_ff, bracket_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [AIW-1:0]       idx_ff, idx_in;
   logic [AIW-1:0]       emit_ff, emit_in;
   logic                 drop_ff, drop_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0]    rsp_raw_ff, rsp_raw_in;
   logic [CMD_W-1:0]     rsp_cmd_ff, rsp_cmd_in;
   logic [ARG_SEL_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [ARG_SEL_W-1:0] rsp_aidx_ff, rsp_aidx_in;
   logic [ARG_VAL_W-1:0] rsp_val_ff, rsp_val_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [BYTE_W-1:0]    buf_mem [BUFFER_DEPTH];
   logic [BYTE_W-1:0]    buf_rdata_ff;
   logic                 buf_wr_en;
   logic [BIW-1:0]       buf_wr_addr;

   arg_ctl_type          arg_ctl;
   logic [ARG_VAL_W-1:0] arg_value;

   logic                 out_free;
   logic                 req_beat;
   logic [CMD_W:0]       lookup;
   logic                 scan_more;
   logic                 can_advance;
   logic [BYTE_W-1:0]    in_byte;

   assign in_byte     = req_tdata;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == IDLE) && out_free;
   assign req_beat    = req_tvalid && req_tready;
   assign lookup      = final_lookup(in_byte);
   assign scan_more   = ((CNT_W + 1)'(ptr_ff) + 1'b1) < (CNT_W + 1)'(count_ff);
   assign can_advance = ((AIW + 1)'(idx_ff) + 1'b1) < (AIW + 1)'(MAX_ARGS);

   assign buf_wr_addr = (in_byte == CH_ESC) ? '0 : count_ff[BIW-1:0];

   // Sequencer: next state, counters and the output register.
   always_comb begin
      state_in       = state_ff;
      ansi_enable_in = csr_wr_en ? csr_wr_data : ansi_enable_ff;
      count_in       = count_ff;
      ptr_in         = ptr_ff;
      bracket_in     = bracket_ff;
      cmd_in         = cmd_ff;
      idx_in         = idx_ff;
      emit_in        = emit_ff;
      drop_in        = drop_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_raw_in     = rsp_raw_ff;
      rsp_cmd_in     = rsp_cmd_ff;
      rsp_cnt_in     = rsp_cnt_ff;
      rsp_aidx_in    = rsp_aidx_ff;
      rsp_val_in     = rsp_val_ff;
      rsp_last_in    = rsp_last_ff;
      buf_wr_en      = 1'b0;
      arg_ctl.op     = ARG_NOP;
      arg_ctl.wr_idx = ARG_SEL_W'(idx_ff);
      arg_ctl.digit  = '0;

      case (state_ff)
         IDLE: begin
            if (req_beat) begin
               arg_ctl.op = ARG_CLEAR;
               idx_in     = '0;
               drop_in    = 1'b0;
               emit_in    = '0;
               if (!ansi_enable_ff) begin
                  // Processing off: pass the byte straight through.
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_RAW;
                  rsp_raw_in   = in_byte;
                  rsp_cmd_in   = '0;
                  rsp_cnt_in   = '0;
                  rsp_aidx_in  = '0;
                  rsp_val_in   = '0;
                  rsp_last_in  = 1'b1;
               end else if (in_byte == CH_ESC) begin
                  // ESC opens a new sequence and drops any old one.
                  buf_wr_en = 1'b1;
                  count_in  = CNT_W'(1);
               end else if (count_ff != '0 && count_ff < CNT_W'(BUFFER_DEPTH)) begin
                  buf_wr_en = 1'b1;
                  count_in  = count_ff + 1'b1;
                  if (count_ff == CNT_W'(1)) begin
                     bracket_in = (in_byte == CH_LBRACKET);
                  end
                  if (is_final(in_byte)) begin
                     if (count_ff > CNT_W'(1) && bracket_ff && lookup[CMD_W]) begin
                        cmd_in   = lookup[CMD_W-1:0];
                        ptr_in   = CNT_W'(2);
                        state_in = PARSE_RD;
                     end else begin
                        ptr_in   = '0;
                        state_in = REP_RD;
                     end
                  end else if (count_ff == CNT_W'(BUFFER_DEPTH - 1)) begin
                     // Buffer full without a final: flush it raw.
                     ptr_in   = '0;
                     state_in = REP_RD;
                  end
               end else begin
                  if (count_ff >= CNT_W'(BUFFER_DEPTH)) begin
                     count_in = '0;
                  end
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_RAW;
                  rsp_raw_in   = in_byte;
                  rsp_cmd_in   = '0;
                  rsp_cnt_in   = '0;
                  rsp_aidx_in  = '0;
                  rsp_val_in   = '0;
                  rsp_last_in  = 1'b1;
               end
            end
         end

         PARSE_RD: begin
            state_in = scan_more ? PARSE_EX : COMMIT;
         end

         PARSE_EX: begin
            // Digits feed the accumulator, a separator closes an argument.
            if (buf_rdata_ff inside {[CH_ZERO:CH_NINE]}) begin
               if (!drop_ff) begin
                  arg_ctl.op    = ARG_DIGIT;
                  arg_ctl.digit = DIGIT_W'(buf_rdata_ff - CH_ZERO);
               end
            end else if (buf_rdata_ff == CH_SEMI) begin
               if (can_advance) begin
                  arg_ctl.op = ARG_COMMIT;
                  idx_in     = idx_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
            end
            ptr_in   = ptr_ff + 1'b1;
            state_in = PARSE_RD;
         end

         COMMIT: begin
            arg_ctl.op = ARG_COMMIT;
            emit_in    = '0;
            state_in   = EMIT_RD;
         end

         EMIT_RD: begin
            state_in = EMIT_OUT;
         end

         EMIT_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ARG;
               rsp_raw_in   = '0;
               rsp_cmd_in   = cmd_ff;
               rsp_cnt_in   = ARG_SEL_W'(idx_ff) + 1'b1;
               rsp_aidx_in  = ARG_SEL_W'(emit_ff);
               rsp_val_in   = arg_value;
               rsp_last_in  = (emit_ff == idx_ff);
               if (emit_ff == idx_ff) begin
                  count_in = '0;
                  state_in = IDLE;
               end else begin
                  emit_in  = emit_ff + 1'b1;
                  state_in = EMIT_RD;
               end
            end
         end

         REP_RD: begin
            state_in = REP_OUT;
         end

         REP_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_RAW;
               rsp_raw_in   = buf_rdata_ff;
               rsp_cmd_in   = '0;
               rsp_cnt_in   = '0;
               rsp_aidx_in  = '0;
               rsp_val_in   = '0;
               rsp_last_in  = !scan_more;
               if (!scan_more) begin
                  count_in = '0;
                  state_in = IDLE;
               end else begin
                  ptr_in   = ptr_ff + 1'b1;
                  state_in = REP_RD;
               end
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= IDLE;
         ansi_enable_ff <= 1'b1;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         ansi_enable_ff <= ansi_enable_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      ptr_ff      <= ptr_in;
      bracket_ff  <= bracket_in;
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      emit_ff     <= emit_in;
      drop_ff     <= drop_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_raw_ff  <= rsp_raw_in;
      rsp_cmd_ff  <= rsp_cmd_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_aidx_ff <= rsp_aidx_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Sequence buffer: one write port, one registered read at the scan pointer.
   always_ff @(posedge clock) begin
      buf_rdata_ff <= buf_mem[ptr_ff[BIW-1:0]];
      if (buf_wr_en) begin
         buf_mem[buf_wr_addr] <= in_byte;
      end
   end

   acsp_arg_unit #(
      .MAX_ARGS (MAX_ARGS)
   ) u_arg_unit (
      .clock    (clock),
      .ctl      (arg_ctl),
      .rd_idx   (emit_ff),
      .rd_value (arg_value)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_val_ff, rsp_aidx_ff, rsp_cnt_ff, rsp_cmd_ff, rsp_raw_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // With processing off, a byte yields exactly one raw result from the output register.
   assert property (@(posedge clock) disable iff (reset)
      (req_beat && !ansi_enable_ff) |=> (rsp_valid_ff && rsp_kind_ff == KIND_RAW && rsp_last_ff))
      else $error("pass-through byte did not produce a single raw result");

   // Between items the buffer never stands full.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE) |-> (count_ff < CNT_W'(BUFFER_DEPTH)))
      else $error("sequence buffer left full while idle");

   // A decoded argument always lies inside its command's argument count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_ARG) |-> (rsp_aidx_ff < rsp_cnt_ff))
      else $error("argument index outside argument count");

   // The argument index stays below the argument limit while emitting.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == EMIT_OUT) |-> ((AIW + 1)'(idx_ff) < (AIW + 1)'(MAX_ARGS)))
      else $error("argument index beyond limit");

endmodule

/* sv/acsp_arg_unit.sv */
module acsp_arg_unit #(
   parameter int MAX_ARGS = acsp_pkg::DEF_MAX_ARGS
) (
   input  logic                             clock,
   input  acsp_pkg::arg_ctl_type            ctl,
   input  logic [((MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1)-1:0] rd_idx,
   output logic [acsp_pkg::ARG_VAL_W-1:0]   rd_value
);
   import acsp_pkg::*;

   localparam int AIW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;

   logic [ARG_VAL_W-1:0] acc_ff;
   logic [ARG_VAL_W-1:0] acc_in;
   logic [ARG_VAL_W-1:0] arg_mem [MAX_ARGS];
   logic [ARG_VAL_W-1:0] rd_value_ff;

   // Shared multiply-by-ten and add, wrapping at the argument width.
   always_comb begin
      case (ctl.op)
         ARG_CLEAR:  acc_in = '0;
         ARG_DIGIT:  acc_in = (acc_ff << 3) + (acc_ff << 1) + ARG_VAL_W'(ctl.digit);
         ARG_COMMIT: acc_in = '0;
         default:    acc_in = acc_ff;
      endcase
   end

   // Accumulator, argument store with one write and one registered read.
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      rd_value_ff <= arg_mem[rd_idx];
      if (ctl.op == ARG_COMMIT) begin
         arg_mem[ctl.wr_idx[AIW-1:0]] <= acc_ff;
      end
   end

   assign rd_value = rd_value_ff;

endmodule

/* bench/tb_ansi_csi_sequence_parser.sv */
module tb_ansi_csi_sequence_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import acsp_pkg::*;

   localparam int BUF_DEPTH = DEF_BUFFER_DEPTH;
   localparam int ARG_LIMIT = DEF_MAX_ARGS;
   localparam int N_CMDS    = int'(CMD_SGR) + 1;
   // Cycles to let the block settle once no result beat is outstanding.
   localparam int SETTLE_CYCLES = 40;

   // Letter ranges that close a sequence.
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;

   // One result beat, split into its fields.
   typedef struct packed {
      logic                 kind;
      logic [7:0]           raw_byte;
      logic [CMD_W-1:0]     command;
      logic [ARG_SEL_W-1:0] arg_total;
      logic [ARG_SEL_W-1:0] arg_index;
      logic [ARG_VAL_W-1:0] arg_value;
      logic                 last;
   } rsp_beat_type;

   // Predicts the console parser and checks its result beats in order.
   class csi_scoreboard;
      logic         ansi_on;
      logic [7:0]   seq_buf [BUF_DEPTH];
      int unsigned  seq_len;
      logic [7:0]   final_of [N_CMDS];
      rsp_beat_type expected_q [$];
      int           mismatches;
      int           beats_seen;
      int           raw_beats;
      int           arg_beats;
      bit           cmd_hit [N_CMDS];

      function new();
         ansi_on    = 1'b1;
         seq_len    = 0;
         mismatches = 0;
         beats_seen = 0;
         raw_beats  = 0;
         arg_beats  = 0;
         final_of[CMD_INSERT] = "@";
         final_of[CMD_UP]     = "A";
         final_of[CMD_DOWN]   = "B";
         final_of[CMD_FWD]    = "C";
         final_of[CMD_BACK]   = "D";
         final_of[CMD_ED]     = "J";
         final_of[CMD_EL]     = "K";
         final_of[CMD_DCH]    = "P";
         final_of[CMD_CUP]    = "H";
         final_of[CMD_SGR]    = "m";
         foreach (cmd_hit[k]) cmd_hit[k] = 1'b0;
      endfunction

      static function bit is_letter(logic [7:0] b);
         return (b >= "@" && b <= "Z") || (b >= "a" && b <= "z");
      endfunction

      // Command code of a final letter, or -1 when the letter is not a command.
      function int code_of(logic [7:0] b);
         int code;
         code = -1;
         for (int k = CMD_INSERT; k <= CMD_SGR; k++) begin
            if (final_of[k] == b) code = k;
         end
         return code;
      endfunction

      function void set_ansi(logic en);
         ansi_on = en;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void push_raw(logic [7:0] b);
         rsp_beat_type t;
         t          = '0;
         t.kind     = KIND_RAW;
         t.raw_byte = b;
         expected_q.push_back(t);
      endfunction

      // Print the buffered bytes back and close the sequence.
      function void replay_seq();
         for (int i = 0; i < seq_len; i++) push_raw(seq_buf[i]);
         seq_len = 0;
      endfunction

      // Decode a closed sequence into argument beats, or replay it.
      function void decode_seq();
         logic [ARG_VAL_W-1:0] args [ARG_LIMIT];
         int unsigned          idx;
         bit                   dropping;
         logic [7:0]           c;
         int                   code;
         rsp_beat_type         t;
         if (seq_len < 2 || seq_buf[0] != CH_ESC || seq_buf[1] != CH_LBRACKET) begin
            replay_seq();
            return;
         end
         code = code_of(seq_buf[seq_len-1]);
         if (code < 0) begin
            replay_seq();
            return;
         end
         foreach (args[k]) args[k] = '0;
         idx      = 0;
         dropping = 1'b0;
         for (int i = 2; i + 1 < seq_len; i++) begin
            c = seq_buf[i];
            if (c >= CH_ZERO && c <= CH_NINE) begin
               if (!dropping) args[idx] = args[idx] * 16'd10 + 16'(c - CH_ZERO);
            end else if (c == CH_SEMI) begin
               // Past the last argument slot further separators are dropped.
               if (idx + 1 < ARG_LIMIT) idx++;
               else dropping = 1'b1;
            end
         end
         cmd_hit[code] = 1'b1;
         for (int i = 0; i <= idx; i++) begin
            t           = '0;
            t.kind      = KIND_ARG;
            t.command   = CMD_W'(code);
            t.arg_total = ARG_SEL_W'(idx + 1);
            t.arg_index = ARG_SEL_W'(i);
            t.arg_value = args[i];
            expected_q.push_back(t);
         end
         seq_len = 0;
      endfunction

      // Note one accepted input beat and queue the results it causes.
      function void note_byte(logic [7:0] b);
         int           first;
         rsp_beat_type t;
         first = expected_q.size();
         if (!ansi_on) begin
            push_raw(b);
         end else if (b == CH_ESC) begin
            seq_buf[0] = b;
            seq_len    = 1;
         end else if (seq_len > 0 && seq_len < BUF_DEPTH) begin
            seq_buf[seq_len] = b;
            seq_len++;
            if (is_letter(b)) decode_seq();
            else if (seq_len >= BUF_DEPTH) replay_seq();
         end else begin
            push_raw(b);
         end
         if (expected_q.size() > first) begin
            t      = expected_q.pop_back();
            t.last = 1'b1;
            expected_q.push_back(t);
         end
      endfunction

      function string fmt_beat(rsp_beat_type t);
         return $sformatf("kind=%0d raw=%02h cmd=%0d cnt=%0d idx=%0d val=%0d last=%0d",
                          t.kind, t.raw_byte, t.command, t.arg_total, t.arg_index,
                          t.arg_value, t.last);
      endfunction

      // Compare one accepted result beat with the oldest expected one.
      function void check_beat(rsp_beat_type got);
         rsp_beat_type want;
         beats_seen++;
         if (got.kind == KIND_RAW) raw_beats++;
         else arg_beats++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: beat %0d arrived with nothing due: %s",
                        beats_seen, fmt_beat(got));
            return;
         end
         want = expected_q.pop_front();
         if (got.kind !== want.kind || got.raw_byte !== want.raw_byte ||
             got.command !== want.command || got.arg_total !== want.arg_total ||
             got.arg_index !== want.arg_index || got.arg_value !== want.arg_value ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: beat %0d expected %s, got %s",
                        beats_seen, fmt_beat(want), fmt_beat(got));
         end
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic [7:0]  req_tdata   = 8'h00;
   logic        rsp_tready  = 1'b0;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b1;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   csi_scoreboard sb = new();
   bit            calm = 1'b0;
   int            items_sent = 0;
   int            phases = 0;

   ansi_csi_sequence_parser #(
      .BUFFER_DEPTH(BUF_DEPTH),
      .MAX_ARGS    (ARG_LIMIT)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result channel ready: long open stretches with random stall bursts.
   initial begin : rsp_ready_driver
      forever begin
         @(posedge clock);
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!calm && $urandom_range(0, 1) == 1) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   // Every accepted result beat goes to the scoreboard.
   always @(posedge clock) begin : rsp_monitor
      rsp_beat_type got;
      got.kind      = rsp_tuser;
      got.raw_byte  = rsp_tdata[7:0];
      got.command   = rsp_tdata[11:8];
      got.arg_total = rsp_tdata[15:12];
      got.arg_index = rsp_tdata[19:16];
      got.arg_value = rsp_tdata[35:20];
      got.last      = rsp_tlast;
      if (!reset && rsp_tvalid && rsp_tready) sb.check_beat(got);
   end

   // Offer one byte, sometimes with a random gap ahead of it, and wait until it is accepted.
   task automatic send_byte(input logic [7:0] b);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_byte(b);
      items_sent++;
   endtask

   task automatic send_bytes(input logic [7:0] s [$]);
      foreach (s[k]) send_byte(s[k]);
   endtask

   // Wait until every expected beat is in and the block has gone quiet.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ansi(input logic en);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= en;
      @(posedge clock);
      sb.set_ansi(en);
      csr_wr_en   <= 1'b0;
      phases++;
   endtask

   // A byte that neither closes nor opens a sequence and is no digit or separator.
   function automatic logic [7:0] pick_filler();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (csi_scoreboard::is_letter(b) || b == CH_ESC || b == CH_SEMI ||
             (b >= CH_ZERO && b <= CH_NINE));
      return b;
   endfunction

   function automatic logic [7:0] pick_unknown_final();
      logic [7:0] b;
      do b = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(CH_AT, CH_UP_Z))
                                          : 8'($urandom_range(CH_LOW_A, CH_LOW_Z));
      while (sb.code_of(b) >= 0);
      return b;
   endfunction

   function automatic logic [7:0] pick_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // A well-formed control sequence with random arguments and a known final.
   task automatic send_csi();
      logic [7:0] s [$];
      int         n_args;
      int         n_dig;
      bit         crowded;
      s.push_back(CH_ESC);
      s.push_back(CH_LBRACKET);
      crowded = ($urandom_range(0, 7) == 0);
      n_args  = crowded ? $urandom_range(9, 12) : $urandom_range(1, 3);
      for (int a = 0; a < n_args; a++) begin
         if (a > 0) s.push_back(CH_SEMI);
         if (crowded) n_dig = ($urandom_range(0, 3) == 0) ? 1 : 0;
         else if ($urandom_range(0, 5) == 0) n_dig = $urandom_range(4, 6);
         else n_dig = $urandom_range(0, 3);
         repeat (n_dig) s.push_back(pick_digit());
         if (!crowded && $urandom_range(0, 9) == 0) s.push_back(pick_filler());
      end
      s.push_back(sb.final_of[$urandom_range(CMD_INSERT, CMD_SGR)]);
      send_bytes(s);
   endtask

   // Sequences that must be replayed, restarted or saturated.
   task automatic send_broken();
      logic [7:0] s [$];
      logic [7:0] b;
      s.push_back(CH_ESC);
      case ($urandom_range(0, 4))
         0: begin
            // Second byte is not an opening bracket.
            do b = 8'($urandom_range(0, 255));
            while (b == CH_LBRACKET || b == CH_ESC);
            s.push_back(b);
            if (!csi_scoreboard::is_letter(b)) begin
               repeat ($urandom_range(0, 3)) s.push_back(pick_filler());
               s.push_back(($urandom_range(0, 1) == 1) ?
                           sb.final_of[$urandom_range(CMD_INSERT, CMD_SGR)] :
                           pick_unknown_final());
            end
         end
         1: begin
            // Final letter that names no command.
            s.push_back(CH_LBRACKET);
            repeat ($urandom_range(0, 3)) s.push_back(pick_digit());
            s.push_back(pick_unknown_final());
         end
         2: begin
            // The buffer fills up without a final letter.
            repeat (BUF_DEPTH - 1) s.push_back(pick_filler());
         end
         3: begin
            // A new escape cuts the open sequence short.
            s.push_back(CH_LBRACKET);
            repeat ($urandom_range(0, 4)) s.push_back(pick_digit());
         end
         default: begin
            // More separators than argument slots.
            s.push_back(CH_LBRACKET);
            s.push_back(pick_digit());
            repeat ($urandom_range(ARG_LIMIT, ARG_LIMIT + 1)) s.push_back(CH_SEMI);
            s.push_back(pick_digit());
            s.push_back(sb.final_of[$urandom_range(CMD_INSERT, CMD_SGR)]);
         end
      endcase
      send_bytes(s);
   endtask

   task automatic random_phase(input int n_items);
      int stop;
      int pick;
      stop = items_sent + n_items;
      while (items_sent < stop) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) send_csi();
         else if (pick < 8) send_broken();
         else repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_ansi(1'b1);

      // Directed: extreme bytes, a cursor move, a restart with a wrapping
      // argument, a bad second byte and an unknown final.
      send_bytes('{8'h00, 8'hFF});
      send_bytes('{CH_ESC, CH_LBRACKET, "1", CH_SEMI, "2", "H"});
      send_bytes('{CH_ESC, CH_LBRACKET, "7", CH_ESC, CH_LBRACKET,
                   "9", "9", "9", "9", "9", "m"});
      send_bytes('{CH_ESC, "X"});
      send_bytes('{CH_ESC, CH_LBRACKET, "Z"});

      // An open sequence survives a stretch with processing turned off.
      send_bytes('{CH_ESC, CH_LBRACKET, "3", CH_SEMI});
      drain();
      write_ansi(1'b0);
      send_bytes('{"A", CH_ESC});
      drain();
      write_ansi(1'b1);
      send_byte("C");

      random_phase(170);
      drain();
      write_ansi(1'b0);
      random_phase(40);
      drain();
      write_ansi(1'b1);

      // Closing stretch runs with no idling on either side.
      calm = 1'b1;
      random_phase(100);
      req_tvalid <= 1'b0;
      for (int w = 0; w < 20000 && sb.pending() > 0; w++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.pending() > 0)
         $display("ERROR: %0d expected result beats never arrived", sb.pending());
      $display("Sent %0d bytes over %0d register settings; checked %0d result beats",
               items_sent, phases, sb.beats_seen);
      $display("(%0d raw, %0d argument), %0d mismatches; commands decoded: %0d of %0d.",
               sb.raw_beats, sb.arg_beats, sb.mismatches,
               sb.cmd_hit.sum() with (int'(item)), N_CMDS);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #1_500_000;
      $display("FAIL");
      $finish;
   end

endmodule
